### sv/rrt_pkg.sv
`default_nettype none

package rrt_pkg;

   // command codes
   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_ROUTE  = 2'd1;
   localparam logic [1:0] CMD_DROP   = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] device_uid;
      logic [7:0]  function_code;
      logic [3:0]  seq_number;
      logic        reply_expected;
      logic [3:0]  conn_id;
   } req_type;

   typedef struct packed {
      logic       route_found;
      logic [3:0] dest_conn;
   } rsp_type;

   // one table entry as held in the ram
   typedef struct packed {
      logic [31:0] uid;
      logic [7:0]  func;
      logic [3:0]  sequence_no;
      logic [3:0]  conn;
      logic [31:0] stamp;
   } slot_type;

   // work decided at transfer time
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_RECORD,
      ACT_ROUTE,
      ACT_DROP
   } act_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // sequencer strobes
   typedef struct packed {
      logic scan;
      logic chk;
      logic commit;
   } ctrl_type;

endpackage

`default_nettype wire

### sv/response_routing_table_top.sv
`default_nettype none

// channel  | dir | handshake            | payload
// req_     | in  | req_valid/req_ready  | rrt_pkg::req_type
// rsp_     | out | rsp_valid/rsp_ready  | rrt_pkg::rsp_type
//
// an item with table work (record, route, disconnect in range) is scanned one ram entry per
// cycle before its commit step; an item without table work goes straight to the commit step
// the ram read is registered, so the scan drains in the cycle after the last address
// reset clears the used bits and the request counter at once; no clearing pass
// a new item is taken while the previous result still waits in the output register
// the commit step holds until the output register is free

module response_routing_table_top #(
   parameter int TABLE_ENTRIES = 32,
   parameter int CONNECTIONS   = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rrt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rrt_pkg::rsp_type      rsp_data
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int SLOT_W = $bits(rrt_pkg::slot_type);

   // request held for the whole scan
   rrt_pkg::req_type  req_ff;
   rrt_pkg::act_type  act_ff, act_in;
   logic [31:0]       count_ff, count_in;

   // per-entry used bits
   logic [TABLE_ENTRIES-1:0] used_ff, used_in;

   // scan results
   logic              free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              best_vld_ff, best_vld_in;
   logic [31:0]       best_age_ff, best_age_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [3:0]        best_conn_ff, best_conn_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rrt_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   rrt_pkg::ctrl_type ctrl;
   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W-1:0]  chk_idx;
   logic              req_xfer;
   logic              out_free;
   logic              scan_need;

   rrt_pkg::slot_type rd_slot;
   rrt_pkg::slot_type wr_slot;
   logic              wr_en;
   logic [IDX_W-1:0]  target;

   logic              chk_used;
   logic              chk_hit;
   logic              cand;
   logic [31:0]       age;
   logic              take;

   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // decide the work at transfer time; broadcasts and stray commands do nothing
   always_comb begin
      act_in = rrt_pkg::ACT_NONE;
      case (req_data.command)
         rrt_pkg::CMD_RECORD: begin
            if (req_data.seq_number != '0 && req_data.device_uid != '0 &&
                req_data.reply_expected) begin
               act_in = rrt_pkg::ACT_RECORD;
            end
         end
         rrt_pkg::CMD_ROUTE: begin
            if (req_data.seq_number != '0 && req_data.device_uid != '0) begin
               act_in = rrt_pkg::ACT_ROUTE;
            end
         end
         rrt_pkg::CMD_DROP: begin
            if (req_data.conn_id != '0 && 32'(req_data.conn_id) < CONNECTIONS) begin
               act_in = rrt_pkg::ACT_DROP;
            end
         end
         default: begin
            act_in = rrt_pkg::ACT_NONE;
         end
      endcase
   end

   assign scan_need = (act_in != rrt_pkg::ACT_NONE);

   // counter moves only for a stored request
   assign count_in = (req_xfer && act_in == rrt_pkg::ACT_RECORD) ? count_ff + 32'd1 : count_ff;

   rrt_seq #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_accept(req_xfer),
      .scan_need (scan_need),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctrl      (ctrl),
      .rd_idx    (rd_idx),
      .chk_idx   (chk_idx)
   );

   // free entry wins, otherwise the oldest one is evicted
   assign target = free_vld_ff ? free_idx_ff : best_idx_ff;
   assign wr_en  = ctrl.commit && (act_ff == rrt_pkg::ACT_RECORD);

   always_comb begin
      wr_slot.uid         = req_ff.device_uid;
      wr_slot.func        = req_ff.function_code;
      wr_slot.sequence_no = req_ff.seq_number;
      wr_slot.conn        = req_ff.conn_id;
      wr_slot.stamp       = count_ff;
   end

   rrt_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (target),
      .wr_data   (wr_slot),
      .rd_addr   (rd_idx),
      .rd_data_ff(rd_slot)
   );

   // entry under check this cycle
   assign chk_used = used_ff[chk_idx];
   assign chk_hit  = chk_used && rd_slot.uid == req_ff.device_uid &&
                     rd_slot.func == req_ff.function_code &&
                     rd_slot.sequence_no == req_ff.seq_number;

   always_comb begin
      cand = 1'b0;
      if (ctrl.chk) begin
         case (act_ff)
            rrt_pkg::ACT_RECORD: cand = chk_used;
            rrt_pkg::ACT_ROUTE:  cand = chk_hit;
            default:             cand = 1'b0;
         endcase
      end
   end

   rrt_age_unit u_age (
      .cand    (cand),
      .count   (count_ff),
      .stamp   (rd_slot.stamp),
      .best_vld(best_vld_ff),
      .best_age(best_age_ff),
      .age     (age),
      .take    (take)
   );

   // scan bookkeeping and used bits
   always_comb begin
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      best_vld_in  = best_vld_ff;
      best_age_in  = best_age_ff;
      best_idx_in  = best_idx_ff;
      best_conn_in = best_conn_ff;
      used_in      = used_ff;

      if (req_xfer) begin
         free_vld_in = 1'b0;
         best_vld_in = 1'b0;
      end

      // first free entry in index order
      if (ctrl.chk && act_ff == rrt_pkg::ACT_RECORD && !chk_used && !free_vld_ff) begin
         free_vld_in = 1'b1;
         free_idx_in = chk_idx;
      end

      if (take) begin
         best_vld_in  = 1'b1;
         best_age_in  = age;
         best_idx_in  = chk_idx;
         best_conn_in = rd_slot.conn;
      end

      // disconnect frees every entry of the connection
      if (ctrl.chk && act_ff == rrt_pkg::ACT_DROP && chk_used &&
          rd_slot.conn == req_ff.conn_id) begin
         used_in[chk_idx] = 1'b0;
      end

      if (wr_en) begin
         used_in[target] = 1'b1;
      end

      // a routed response frees its entry
      if (ctrl.commit && act_ff == rrt_pkg::ACT_ROUTE && best_vld_ff) begin
         used_in[best_idx_ff] = 1'b0;
      end
   end

   // result goes to the output register at commit
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.commit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.route_found = (act_ff == rrt_pkg::ACT_ROUTE) && best_vld_ff;
         rsp_data_in.dest_conn   = rsp_data_in.route_found ? best_conn_ff : 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         count_ff     <= '0;
         act_ff       <= rrt_pkg::ACT_NONE;
         rsp_valid_ff <= 1'b0;
         free_vld_ff  <= 1'b0;
         best_vld_ff  <= 1'b0;
      end else begin
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         free_vld_ff  <= free_vld_in;
         best_vld_ff  <= best_vld_in;
         if (req_xfer) begin
            act_ff <= act_in;
         end
      end
      if (req_xfer) begin
         req_ff <= req_data;
      end
      free_idx_ff  <= free_idx_in;
      best_age_ff  <= best_age_in;
      best_idx_ff  <= best_idx_in;
      best_conn_ff <= best_conn_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_count_only_on_xfer: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> $stable(count_ff))
      else $error("request counter moved without a transfer");

   a_record_sets_used: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> used_ff[$past(target)])
      else $error("recorded entry not marked used");

   a_miss_has_no_dest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.route_found) |-> (rsp_data_ff.dest_conn == 4'd0))
      else $error("destination given without a route");

   a_commit_frees_output: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |-> out_free)
      else $error("result overwritten before transfer");

endmodule

`default_nettype wire

### sv/rrt_ram.sv
`default_nettype none

module rrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### sv/rrt_age_unit.sv
`default_nettype none

// modular age of one entry and compare against the best so far
module rrt_age_unit (
   input  wire logic        cand,
   input  wire logic [31:0] count,
   input  wire logic [31:0] stamp,
   input  wire logic        best_vld,
   input  wire logic [31:0] best_age,
   output logic [31:0]      age,
   output logic             take
);

   always_comb begin
      age  = count - stamp;
      // strict compare keeps the lowest index on a tie
      take = cand && (!best_vld || (age > best_age));
   end

endmodule

`default_nettype wire

### sv/rrt_seq.sv
`default_nettype none

module rrt_seq #(
   parameter int TABLE_ENTRIES = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_accept,
   input  wire logic                             scan_need,
   input  wire logic                             out_free,
   output logic                                  req_ready,
   output rrt_pkg::ctrl_type                     ctrl,
   output logic [$clog2(TABLE_ENTRIES)-1:0]      rd_idx,
   output logic [$clog2(TABLE_ENTRIES)-1:0]      chk_idx
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   rrt_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   chk_idx_ff;
   logic               chk_vld_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrt_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = scan_need ? rrt_pkg::ST_SCAN : rrt_pkg::ST_COMMIT;
            end
         end
         rrt_pkg::ST_SCAN: begin
            if (rd_idx_ff == LAST_IDX) begin
               state_in = rrt_pkg::ST_DRAIN;
            end
         end
         rrt_pkg::ST_DRAIN: begin
            state_in = rrt_pkg::ST_COMMIT;
         end
         rrt_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = rrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrt_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      ctrl.scan   = 1'b0;
      ctrl.commit = 1'b0;
      rd_idx_in   = rd_idx_ff;
      case (state_ff)
         rrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_idx_in = '0;
         end
         rrt_pkg::ST_SCAN: begin
            ctrl.scan = 1'b1;
            rd_idx_in = rd_idx_ff + 1'b1;
         end
         rrt_pkg::ST_COMMIT: begin
            ctrl.commit = out_free;
         end
         default: begin
         end
      endcase
      ctrl.chk = chk_vld_ff;
      rd_idx   = rd_idx_ff;
      chk_idx  = chk_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rrt_pkg::ST_IDLE;
         chk_vld_ff <= 1'b0;
         rd_idx_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= ctrl.scan;
         rd_idx_ff  <= rd_idx_in;
      end
      chk_idx_ff <= rd_idx_ff;
   end

   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == rrt_pkg::ST_SCAN || state_ff == rrt_pkg::ST_DRAIN))
      else $error("entry check outside scan");

   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrt_pkg::ST_DRAIN) |-> (chk_idx_ff == LAST_IDX))
      else $error("drain without last entry");

endmodule

`default_nettype wire
